/* hw/rtl/efp_pkg.sv */
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types and constant text for the escape sequence frame parser.
// ----------------------------------------------------------------------------
package efp_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int ADDR_W      = 4;

    // Byte strings, leftmost character in the highest element
    localparam logic [3:0][7:0]  PREFIX_TEXT = "/^m[";
    localparam logic [2:0][7:0]  ID_CUR_TEXT = "CUR";
    localparam logic [2:0][7:0]  ID_BUF_TEXT = "BUF";
    localparam logic [15:0][7:0] MSG_CUR_TEXT = "\nCursor addres: ";
    localparam logic [14:0][7:0] MSG_BUF_TEXT = "\nFrame buffer: ";

    localparam logic [ADDR_W-1:0] MSG_CUR_LAST = 4'd15;
    localparam logic [ADDR_W-1:0] MSG_BUF_LAST = 4'd14;

    localparam logic [7:0] SLASH_CHAR = 8'h2f;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_ID   = 4'b0010,
        PH_CUR  = 4'b0100,
        PH_FRM  = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        EM_IDLE = 4'b0001,
        EM_MSG  = 4'b0010,
        EM_RD   = 4'b0100,
        EM_WR   = 4'b1000
    } emit_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        return PREFIX_TEXT[2'(2'd3 - pos)];
    endfunction

    function automatic logic [7:0] id_cur_char(input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (pos)
            2'd0:    c = ID_CUR_TEXT[2];
            2'd1:    c = ID_CUR_TEXT[1];
            2'd2:    c = ID_CUR_TEXT[0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] id_buf_char(input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (pos)
            2'd0:    c = ID_BUF_TEXT[2];
            2'd1:    c = ID_BUF_TEXT[1];
            2'd2:    c = ID_BUF_TEXT[0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] msg_char(input logic is_cur,
                                            input logic [ADDR_W-1:0] idx);
        logic [7:0] c;
        if (is_cur)
        begin
            c = MSG_CUR_TEXT[4'(4'd15 - idx)];
        end
        else if (idx == 4'd15)
        begin
            c = 8'h00;
        end
        else
        begin
            c = MSG_BUF_TEXT[4'(4'd14 - idx)];
        end
        return c;
    endfunction

endpackage

/* hw/rtl/efp_store.sv */
// ----------------------------------------------------------------------------
// efp_store
// Data byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module efp_store (
    input  logic              clk,
    input  efp_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import efp_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/escape_sequence_frame_parser.sv */
// ----------------------------------------------------------------------------
// escape_sequence_frame_parser
// Hunts for "/^m[" plus a three-byte id, announces the mode and replays the
// collected data bytes as one run.
// ----------------------------------------------------------------------------
// Bytes that cause no output are taken one per cycle; input is stalled while a
// run is out. Header run (15 or 16 bytes): one byte per cycle while the output is
// not stalled. Data run: each byte is read through the store's registered read
// port, then registered out once the output is free, before the next read.
// Asynchronous active-low reset returns to the hunt with no output pending; the data store is not cleared.
module escape_sequence_frame_parser #(
    parameter int FRAME_BYTES  = 16,
    parameter int CURSOR_BYTES = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);
    import efp_pkg::*;

    localparam int CUR_LIM = (CURSOR_BYTES < 1) ? 1 :
                             (CURSOR_BYTES > STORE_DEPTH) ? STORE_DEPTH : CURSOR_BYTES;
    localparam int FRM_LIM = (FRAME_BYTES < 1) ? 1 :
                             (FRAME_BYTES > STORE_DEPTH) ? STORE_DEPTH : FRAME_BYTES;
    localparam logic [ADDR_W-1:0] CUR_LAST = ADDR_W'(CUR_LIM - 1);
    localparam logic [ADDR_W-1:0] FRM_LAST = ADDR_W'(FRM_LIM - 1);

    phase_t            phase_reg, phase_next;
    emit_state_t       em_reg, em_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic              cur_ok_reg, cur_ok_next;
    logic              buf_ok_reg, buf_ok_next;
    logic              mode_cur_reg, mode_cur_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] end_idx_reg, end_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              last_reg, last_next;

    mem_req_t   mreq;
    logic [7:0] mem_rdata;
    logic       in_take;
    logic       out_free;
    logic       cur_hit;
    logic       buf_hit;
    logic [ADDR_W-1:0] data_last;

    efp_store u_store (
        .clk   (clk),
        .req   (mreq),
        .rdata (mem_rdata)
    );

    assign in_stall = (em_reg != EM_IDLE);
    assign in_take  = in_valid && (em_reg == EM_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign cur_hit   = ((pos_reg == '0) || cur_ok_reg) && (in_byte == id_cur_char(pos_reg[1:0]));
    assign buf_hit   = ((pos_reg == '0) || buf_ok_reg) && (in_byte == id_buf_char(pos_reg[1:0]));
    assign data_last = (phase_reg == PH_CUR) ? CUR_LAST : FRM_LAST;

    always_comb
    begin
        phase_next     = phase_reg;
        em_next        = em_reg;
        pos_next       = pos_reg;
        cur_ok_next    = cur_ok_reg;
        buf_ok_next    = buf_ok_reg;
        mode_cur_next  = mode_cur_reg;
        idx_next       = idx_reg;
        end_idx_next   = end_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;

        mreq.wr_en   = 1'b0;
        mreq.wr_addr = pos_reg;
        mreq.wr_data = in_byte;
        mreq.rd_en   = 1'b0;
        mreq.rd_addr = idx_reg;

        unique case (em_reg)
            EM_IDLE:
            begin
                if (in_take)
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (in_byte == prefix_char(pos_reg[1:0]))
                            begin
                                if (pos_reg[1:0] == 2'd3)
                                begin
                                    phase_next = PH_ID;
                                    pos_next   = '0;
                                end
                                else
                                begin
                                    pos_next = pos_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                // a stray '/' may open a fresh prefix
                                pos_next = (in_byte == SLASH_CHAR) ? ADDR_W'(1) : '0;
                            end
                        end
                        PH_ID:
                        begin
                            cur_ok_next = cur_hit;
                            buf_ok_next = buf_hit;
                            if (pos_reg[1:0] == 2'd2)
                            begin
                                pos_next = '0;
                                idx_next = '0;
                                if (cur_hit)
                                begin
                                    phase_next    = PH_CUR;
                                    mode_cur_next = 1'b1;
                                    end_idx_next  = MSG_CUR_LAST;
                                    em_next       = EM_MSG;
                                end
                                else if (buf_hit)
                                begin
                                    phase_next    = PH_FRM;
                                    mode_cur_next = 1'b0;
                                    end_idx_next  = MSG_BUF_LAST;
                                    em_next       = EM_MSG;
                                end
                                else
                                begin
                                    phase_next = PH_HUNT;
                                end
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                        PH_CUR, PH_FRM:
                        begin
                            mreq.wr_en = 1'b1;
                            if (pos_reg == data_last)
                            begin
                                phase_next   = PH_HUNT;
                                pos_next     = '0;
                                idx_next     = '0;
                                end_idx_next = data_last;
                                em_next      = EM_RD;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
            end
            EM_MSG:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = msg_char(mode_cur_reg, idx_reg);
                    last_next      = (idx_reg == end_idx_reg);
                    if (idx_reg == end_idx_reg)
                    begin
                        em_next = EM_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            EM_RD:
            begin
                mreq.rd_en = 1'b1;
                em_next    = EM_WR;
            end
            EM_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = mem_rdata;
                    last_next      = (idx_reg == end_idx_reg);
                    if (idx_reg == end_idx_reg)
                    begin
                        em_next = EM_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        em_next  = EM_RD;
                    end
                end
            end
            default:
            begin
                em_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            em_reg        <= EM_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            em_reg        <= em_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_ok_reg   <= cur_ok_next;
        buf_ok_reg   <= buf_ok_next;
        mode_cur_reg <= mode_cur_next;
        idx_reg      <= idx_next;
        end_idx_reg  <= end_idx_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

/* hw/rtl/efp_checker.sv */
// ----------------------------------------------------------------------------
// efp_checker
// Port-level checks for the escape sequence frame parser.
// ----------------------------------------------------------------------------
module efp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("stalled result changed");

    // no request is taken while a run is part way out
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
        else $error("input taken during a run");

    // once the final byte of a run leaves, nothing follows in the next cycle
    a_gap_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_of_run |=> !out_valid)
        else $error("result after end of run");

    // a run cannot start right after an unstalled cycle without a request in that cycle
    a_no_spurious_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && !$past(in_stall) |-> $past(in_valid))
        else $error("result without a request");

endmodule

bind escape_sequence_frame_parser efp_checker u_efp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);
